@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the token scanner RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CST_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define CST_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ design/cst_pkg.sv @@
// ----------------------------------------------------------------------------
// cst_pkg
// Types, constants and character helpers for the C subset token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

    localparam int POSITION_BITS = 32;
    localparam int LINE_BITS     = 24;
    localparam int COLUMN_BITS   = 16;
    localparam int LENGTH_BITS   = 16;
    localparam int KIND_BITS     = 5;
    localparam int VALUE_BITS    = 64;
    localparam int PREFIX_BITS   = 48;
    localparam int CMP_BITS      = (POSITION_BITS > COLUMN_BITS) ? POSITION_BITS : COLUMN_BITS;

    // token queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam logic [QPTR_W:0] QROOM = (QPTR_W + 1)'(QDEPTH - 2);

    localparam logic [LENGTH_BITS-1:0] PREFIX_LEN = LENGTH_BITS'(6);

    // token kinds
    localparam logic [KIND_BITS-1:0] KIND_END     = 5'd0;
    localparam logic [KIND_BITS-1:0] KIND_PLUS    = 5'd1;
    localparam logic [KIND_BITS-1:0] KIND_MINUS   = 5'd2;
    localparam logic [KIND_BITS-1:0] KIND_STAR    = 5'd3;
    localparam logic [KIND_BITS-1:0] KIND_SLASH   = 5'd4;
    localparam logic [KIND_BITS-1:0] KIND_LBRACE  = 5'd5;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE  = 5'd6;
    localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 5'd7;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 5'd8;
    localparam logic [KIND_BITS-1:0] KIND_COMMA   = 5'd9;
    localparam logic [KIND_BITS-1:0] KIND_SEMI    = 5'd10;
    localparam logic [KIND_BITS-1:0] KIND_ASSIGN  = 5'd11;
    localparam logic [KIND_BITS-1:0] KIND_EQ      = 5'd12;
    localparam logic [KIND_BITS-1:0] KIND_NE      = 5'd13;
    localparam logic [KIND_BITS-1:0] KIND_GT      = 5'd14;
    localparam logic [KIND_BITS-1:0] KIND_GE      = 5'd15;
    localparam logic [KIND_BITS-1:0] KIND_LT      = 5'd16;
    localparam logic [KIND_BITS-1:0] KIND_LE      = 5'd17;
    localparam logic [KIND_BITS-1:0] KIND_IF      = 5'd18;
    localparam logic [KIND_BITS-1:0] KIND_ELSE    = 5'd19;
    localparam logic [KIND_BITS-1:0] KIND_WHILE   = 5'd20;
    localparam logic [KIND_BITS-1:0] KIND_DO      = 5'd21;
    localparam logic [KIND_BITS-1:0] KIND_FOR     = 5'd22;
    localparam logic [KIND_BITS-1:0] KIND_RETURN  = 5'd23;
    localparam logic [KIND_BITS-1:0] KIND_IDENT   = 5'd24;
    localparam logic [KIND_BITS-1:0] KIND_NUMBER  = 5'd25;
    localparam logic [KIND_BITS-1:0] KIND_ILLEGAL = 5'd26;

    // characters
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_GREATER    = 8'h3E;
    localparam logic [7:0] CH_LESS       = 8'h3C;
    localparam logic [7:0] CH_ZERO       = 8'h30;

    // keywords, first bytes in the high end
    localparam logic [PREFIX_BITS-1:0] KW_IF     = 48'h0000_0000_6966;
    localparam logic [PREFIX_BITS-1:0] KW_DO     = 48'h0000_0000_646F;
    localparam logic [PREFIX_BITS-1:0] KW_FOR    = 48'h0000_0066_6F72;
    localparam logic [PREFIX_BITS-1:0] KW_ELSE   = 48'h0000_656C_7365;
    localparam logic [PREFIX_BITS-1:0] KW_WHILE  = 48'h0077_6869_6C65;
    localparam logic [PREFIX_BITS-1:0] KW_RETURN = 48'h7265_7475_726E;

    typedef enum logic [6:0] {
        MODE_IDLE   = 7'b0000001,
        MODE_IDENT  = 7'b0000010,
        MODE_NUMBER = 7'b0000100,
        MODE_EQ     = 7'b0001000,
        MODE_NOT    = 7'b0010000,
        MODE_GT     = 7'b0100000,
        MODE_LT     = 7'b1000000
    } scan_mode_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]     kind;
        logic [VALUE_BITS-1:0]    value;
        logic [LINE_BITS-1:0]     line;
        logic [COLUMN_BITS-1:0]   column;
        logic [POSITION_BITS-1:0] start;
        logic [LENGTH_BITS-1:0]   length;
        logic                     last;
    } token_t;

    // tokens produced by one byte, oldest in first
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [KIND_BITS-1:0] op_kind(input logic [7:0] c);
        logic [KIND_BITS-1:0] k;
        unique case (c)
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            ",":     k = KIND_COMMA;
            ";":     k = KIND_SEMI;
            default: k = KIND_ILLEGAL;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_BITS-1:0] word_kind(
        input logic [PREFIX_BITS-1:0] p,
        input logic [LENGTH_BITS-1:0] len
    );
        logic [KIND_BITS-1:0] k;
        k = KIND_IDENT;
        if (len == LENGTH_BITS'(2) && p == KW_IF)     k = KIND_IF;
        if (len == LENGTH_BITS'(2) && p == KW_DO)     k = KIND_DO;
        if (len == LENGTH_BITS'(3) && p == KW_FOR)    k = KIND_FOR;
        if (len == LENGTH_BITS'(4) && p == KW_ELSE)   k = KIND_ELSE;
        if (len == LENGTH_BITS'(5) && p == KW_WHILE)  k = KIND_WHILE;
        if (len == LENGTH_BITS'(6) && p == KW_RETURN) k = KIND_RETURN;
        return k;
    endfunction

    // saturate a position difference into a column
    function automatic logic [COLUMN_BITS-1:0] col_sat(input logic [POSITION_BITS-1:0] d);
        logic [CMP_BITS-1:0] dw;
        logic [CMP_BITS-1:0] cmax;
        dw   = CMP_BITS'(d);
        cmax = CMP_BITS'({COLUMN_BITS{1'b1}});
        return (dw > cmax) ? {COLUMN_BITS{1'b1}} : COLUMN_BITS'(dw);
    endfunction

endpackage

`default_nettype wire

@@ design/c_subset_token_scanner.sv @@
// ----------------------------------------------------------------------------
// c_subset_token_scanner
// Byte-serial lexer for a small C subset: one text byte per beat in, tokens out.
// ----------------------------------------------------------------------------
// A byte is taken into the input register and scanned from there once the
// token queue has room for two tokens; the tokens it closes or makes are
// written into the token queue, from which they are handed out in order.
// Sustained rate is one byte per cycle while the queue has room; a byte that
// closes one token and makes another yields two, held in the 4-entry queue.
// Reset (asynchronous, rst_n low) empties both stages and starts a new text
// at offset 0 on line 1.
`default_nettype none
`include "assert_macros.svh"

module c_subset_token_scanner (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic                              cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [7:0]                        text_byte,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [cst_pkg::KIND_BITS-1:0]          token_kind,
    output logic [cst_pkg::VALUE_BITS-1:0]         number_value,
    output logic [cst_pkg::LINE_BITS-1:0]          token_line,
    output logic [cst_pkg::COLUMN_BITS-1:0]        token_column,
    output logic [cst_pkg::POSITION_BITS-1:0]      token_start,
    output logic [cst_pkg::LENGTH_BITS-1:0]        token_length,
    output logic                                   last_of_run
);
    import cst_pkg::*;

    logic               in_full_reg, in_full_next;
    logic [7:0]         in_byte_reg;
    logic               accept, step, pop;
    logic [QPTR_W:0]    q_count;
    push_t              push;
    token_t             head;

    // scan only when the queue can take two tokens
    assign step     = in_full_reg && (q_count <= QROOM);
    assign in_stall = in_full_reg && !step;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (accept)
            in_full_next = 1'b1;
        else if (step)
            in_full_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else
            in_full_reg <= in_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_byte_reg <= text_byte;
    end

    cst_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .step      (step),
        .byte_in   (in_byte_reg),
        .push      (push)
    );

    cst_tokq u_tokq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .count (q_count)
    );

    assign out_valid    = (q_count != '0);
    assign pop          = out_valid && !out_stall;
    assign token_kind   = head.kind;
    assign number_value = head.value;
    assign token_line   = head.line;
    assign token_column = head.column;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign last_of_run  = head.last;

    `CST_ASSERT(a_in_hold, clk, rst_n, (in_full_reg && !step) |=> (in_full_reg && $stable(in_byte_reg)), "held byte lost or changed")
    `CST_ASSERT(a_in_take, clk, rst_n, accept |=> in_full_reg, "accepted byte not captured")

endmodule

`default_nettype wire

@@ design/cst_core.sv @@
// ----------------------------------------------------------------------------
// cst_core
// Scan state and the combinational step that turns a byte into zero to two tokens.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cst_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_write,
    input  wire logic          cfg_data,
    input  wire logic          step,
    input  wire logic [7:0]    byte_in,
    output cst_pkg::push_t     push
);
    import cst_pkg::*;

    scan_mode_t                 mode_reg, mode_next;
    logic [VALUE_BITS-1:0]      acc_reg, acc_next;
    logic [PREFIX_BITS-1:0]     prefix_reg, prefix_next;
    logic [LENGTH_BITS-1:0]     plen_reg, plen_next;
    logic [POSITION_BITS-1:0]   pos_reg, pos_next;
    logic [LINE_BITS-1:0]       line_reg, line_next;
    logic [POSITION_BITS-1:0]   lstart_reg, lstart_next;
    logic [POSITION_BITS-1:0]   pstart_reg, pstart_next;
    logic [LINE_BITS-1:0]       pline_reg, pline_next;
    logic [COLUMN_BITS-1:0]     pcol_reg, pcol_next;
    logic                       first_line_reg, first_line_next;

    logic [COLUMN_BITS-1:0]     col_here;
    logic [POSITION_BITS-1:0]   pos_inc;
    logic [KIND_BITS-1:0]       one_kind, two_kind;
    token_t                     t0, t1;
    logic                       v0, v1, done;

    assign col_here = col_sat(pos_reg - lstart_reg);
    assign pos_inc  = pos_reg + POSITION_BITS'(1);

    always_comb
    begin
        unique case (mode_reg)
            MODE_EQ:
            begin
                one_kind = KIND_ASSIGN;
                two_kind = KIND_EQ;
            end
            MODE_NOT:
            begin
                one_kind = KIND_ILLEGAL;
                two_kind = KIND_NE;
            end
            MODE_GT:
            begin
                one_kind = KIND_GT;
                two_kind = KIND_GE;
            end
            default:
            begin
                one_kind = KIND_LT;
                two_kind = KIND_LE;
            end
        endcase
    end

    always_comb
    begin
        mode_next       = mode_reg;
        acc_next        = acc_reg;
        prefix_next     = prefix_reg;
        plen_next       = plen_reg;
        pos_next        = pos_reg;
        line_next       = line_reg;
        lstart_next     = lstart_reg;
        pstart_next     = pstart_reg;
        pline_next      = pline_reg;
        pcol_next       = pcol_reg;
        first_line_next = first_line_reg;

        // pending token and token at the current byte
        t0.kind   = KIND_IDENT;
        t0.value  = '0;
        t0.line   = pline_reg;
        t0.column = pcol_reg;
        t0.start  = pstart_reg;
        t0.length = plen_reg;
        t0.last   = 1'b0;
        t1.kind   = KIND_ILLEGAL;
        t1.value  = '0;
        t1.line   = line_reg;
        t1.column = col_here;
        t1.start  = pos_reg;
        t1.length = LENGTH_BITS'(1);
        t1.last   = 1'b1;
        v0   = 1'b0;
        v1   = 1'b0;
        done = 1'b0;

        if (step)
        begin
            unique case (mode_reg)
                MODE_IDENT:
                begin
                    if (is_letter(byte_in) || is_digit(byte_in))
                    begin
                        if (plen_reg < PREFIX_LEN)
                            prefix_next = {prefix_reg[PREFIX_BITS-9:0], byte_in};
                        if (plen_reg != {LENGTH_BITS{1'b1}})
                            plen_next = plen_reg + LENGTH_BITS'(1);
                        pos_next = pos_inc;
                        done     = 1'b1;
                    end
                    else
                    begin
                        v0      = 1'b1;
                        t0.kind = word_kind(prefix_reg, plen_reg);
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_digit(byte_in))
                    begin
                        // times ten as two shifted adds
                        acc_next = {acc_reg[VALUE_BITS-4:0], 3'b000}
                                 + {acc_reg[VALUE_BITS-2:0], 1'b0}
                                 + {{(VALUE_BITS-8){1'b0}}, byte_in - CH_ZERO};
                        if (plen_reg != {LENGTH_BITS{1'b1}})
                            plen_next = plen_reg + LENGTH_BITS'(1);
                        pos_next = pos_inc;
                        done     = 1'b1;
                    end
                    else
                    begin
                        v0       = 1'b1;
                        t0.kind  = KIND_NUMBER;
                        t0.value = acc_reg;
                    end
                end
                MODE_EQ, MODE_NOT, MODE_GT, MODE_LT:
                begin
                    v0 = 1'b1;
                    if (byte_in == CH_EQUAL)
                    begin
                        t0.kind   = two_kind;
                        t0.length = LENGTH_BITS'(2);
                        plen_next = LENGTH_BITS'(2);
                        mode_next = MODE_IDLE;
                        pos_next  = pos_inc;
                        done      = 1'b1;
                    end
                    else
                        t0.kind = one_kind;
                end
                MODE_IDLE:
                begin
                end
                default:
                begin
                end
            endcase

            if (!done)
            begin
                mode_next = MODE_IDLE;
                pos_next  = pos_inc;
                if (byte_in == CH_NUL)
                begin
                    // end token, then restart for a new text
                    v1          = 1'b1;
                    t1.kind     = KIND_END;
                    t1.length   = '0;
                    acc_next    = '0;
                    prefix_next = '0;
                    plen_next   = '0;
                    pos_next    = '0;
                    line_next   = LINE_BITS'(first_line_reg);
                    lstart_next = '0;
                    pstart_next = '0;
                    pline_next  = '0;
                    pcol_next   = '0;
                end
                else if (is_space(byte_in))
                begin
                    if (byte_in == CH_NEWLINE)
                    begin
                        if (line_reg != {LINE_BITS{1'b1}})
                            line_next = line_reg + LINE_BITS'(1);
                        lstart_next = pos_inc;
                    end
                end
                else if (is_letter(byte_in) || is_digit(byte_in) || byte_in == CH_EQUAL
                         || byte_in == CH_BANG || byte_in == CH_GREATER
                         || byte_in == CH_LESS)
                begin
                    // hold the token open until the next byte
                    pstart_next = pos_reg;
                    pline_next  = line_reg;
                    pcol_next   = col_here;
                    plen_next   = LENGTH_BITS'(1);
                    priority if (is_letter(byte_in))
                    begin
                        mode_next   = MODE_IDENT;
                        prefix_next = {{(PREFIX_BITS-8){1'b0}}, byte_in};
                    end
                    else if (is_digit(byte_in))
                    begin
                        mode_next = MODE_NUMBER;
                        acc_next  = {{(VALUE_BITS-8){1'b0}}, byte_in - CH_ZERO};
                    end
                    else if (byte_in == CH_EQUAL)
                        mode_next = MODE_EQ;
                    else if (byte_in == CH_BANG)
                        mode_next = MODE_NOT;
                    else if (byte_in == CH_GREATER)
                        mode_next = MODE_GT;
                    else
                        mode_next = MODE_LT;
                end
                else
                begin
                    v1      = 1'b1;
                    t1.kind = op_kind(byte_in);
                end
            end
        end

        if (cfg_write)
        begin
            first_line_next = cfg_data;
            if (pos_reg == '0 && mode_reg == MODE_IDLE)
                line_next = LINE_BITS'(cfg_data);
        end

        t0.last     = !v1;
        push.count  = {1'b0, v0} + {1'b0, v1};
        push.first  = v0 ? t0 : t1;
        push.second = t1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            acc_reg        <= '0;
            prefix_reg     <= '0;
            plen_reg       <= '0;
            pos_reg        <= '0;
            line_reg       <= LINE_BITS'(1);
            lstart_reg     <= '0;
            pstart_reg     <= '0;
            pline_reg      <= '0;
            pcol_reg       <= '0;
            first_line_reg <= 1'b1;
        end
        else
        begin
            mode_reg       <= mode_next;
            acc_reg        <= acc_next;
            prefix_reg     <= prefix_next;
            plen_reg       <= plen_next;
            pos_reg        <= pos_next;
            line_reg       <= line_next;
            lstart_reg     <= lstart_next;
            pstart_reg     <= pstart_next;
            pline_reg      <= pline_next;
            pcol_reg       <= pcol_next;
            first_line_reg <= first_line_next;
        end
    end

    `CST_ASSERT_NEVER(a_push_count, clk, rst_n, push.count == 2'd3, "more than two tokens from one byte")
    `CST_ASSERT_NEVER(a_push_idle, clk, rst_n, !step && (push.count != 2'd0), "token pushed without a byte")
    `CST_ASSERT_NEVER(a_value_kind, clk, rst_n, (push.count != 2'd0) && (push.first.kind != KIND_NUMBER) && (push.first.value != '0), "value on a non-number token")

endmodule

`default_nettype wire

@@ design/cst_tokq.sv @@
// ----------------------------------------------------------------------------
// cst_tokq
// Small token queue: takes up to two tokens a cycle, hands out one per beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cst_tokq (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cst_pkg::push_t        push,
    input  wire logic                  pop,
    output cst_pkg::token_t            head,
    output logic [cst_pkg::QPTR_W:0]   count
);
    import cst_pkg::*;

    token_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;
    logic [QPTR_W-1:0]  wr_ptr_1;

    assign wr_ptr_1    = wr_ptr_reg + QPTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
    assign count_next  = count_reg + (QPTR_W + 1)'(push.count) - (QPTR_W + 1)'(pop);
    assign head        = mem_reg[rd_ptr_reg];
    assign count       = count_reg;

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `CST_ASSERT_NEVER(a_q_over, clk, rst_n, count_reg > (QPTR_W + 1)'(QDEPTH), "token queue overflow")
    `CST_ASSERT_NEVER(a_q_room, clk, rst_n, (push.count != 2'd0) && (count_reg > QROOM), "push without room")
    `CST_ASSERT_NEVER(a_q_under, clk, rst_n, pop && (count_reg == '0), "pop from empty queue")

endmodule

`default_nettype wire
